// File: rtl/stt_pkg.sv
// Shared types, character codes and small classifier functions for the
// source text tokenizer. No dependencies.
package stt_pkg;

  localparam int LEX_BYTES = 31;   // lexeme bytes carried by one token

  typedef enum logic [4:0] {
    KIND_EOF, KIND_ID, KIND_INT, KIND_FLOAT, KIND_IF, KIND_ELSE, KIND_NUMBER,
    KIND_PLUS, KIND_MINUS, KIND_ASSIGN, KIND_EQ, KIND_GT, KIND_GE, KIND_LT,
    KIND_LE, KIND_SEMI, KIND_LPAREN, KIND_RPAREN, KIND_LBRACE, KIND_RBRACE,
    KIND_ERROR
  } kind_t;

  typedef logic [LEX_BYTES-1:0][7:0] lexeme_t;

  typedef struct packed {
    logic [15:0] line;
    logic [15:0] column;
  } pos_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [4:0]  length;
    lexeme_t     lexeme;
  } token_t;

  // Up to three tokens per source byte
  typedef struct packed {
    logic [1:0]        count;
    token_t [2:0]      tok;
  } step_out_t;

  localparam pos_t POS_ONE = '{line: 16'd1, column: 16'd1};

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_C3     = 8'hC3;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;

  // Keywords, first byte in the low bits
  localparam logic [23:0] KW_INT   = 24'h74_6E_69;
  localparam logic [39:0] KW_FLOAT = 40'h74_61_6F_6C_66;
  localparam logic [15:0] KW_IF    = 16'h66_69;
  localparam logic [31:0] KW_ELSE  = 32'h65_73_6C_65;

  function automatic logic is_alpha(logic [7:0] b);
    return (b inside {[8'h61:8'h7A], [8'h41:8'h5A]});
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b inside {[8'h30:8'h39]});
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return (b == CH_SPACE) || (b inside {[8'h09:8'h0D]});
  endfunction

  // _ @ ! # $ % & * ^ ` ~ | \ ? : . /
  function automatic logic is_punct(logic [7:0] b);
    return (b inside {8'h5F, 8'h40, 8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2A,
                      8'h5E, 8'h60, 8'h7E, 8'h7C, 8'h5C, 8'h3F, 8'h3A, 8'h2E,
                      8'h2F});
  endfunction

  // Second byte of an accepted 0xC3 pair
  function automatic logic is_accent_tail(logic [7:0] b);
    return (b inside {8'hA1, 8'hA9, 8'hAD, 8'hB3, 8'hBA, 8'hB1, 8'hBC, 8'h81,
                      8'h89, 8'h8D, 8'h93, 8'h9A, 8'h91, 8'h9C});
  endfunction

  // Position after one consumed byte, saturating
  function automatic pos_t consume(pos_t p, logic [7:0] b);
    pos_t q;
    q = p;
    if (b == CH_LF) begin
      if (p.line != 16'hFFFF) q.line = p.line + 16'd1;
      q.column = 16'd1;
    end else if (p.column != 16'hFFFF) begin
      q.column = p.column + 16'd1;
    end
    return q;
  endfunction

endpackage

// File: rtl/stt_scan.sv
// Scanner core: scan state, lexeme store and the per-byte next-state and
// token logic. Depends on stt_pkg.
module stt_scan #(
  parameter int LEXEME_CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         text_byte,
  input  logic               restart,
  output stt_pkg::step_out_t result
);

  localparam int CNT_W  = $clog2(LEXEME_CAPACITY);
  localparam int VIEW_N = (LEXEME_CAPACITY < stt_pkg::LEX_BYTES) ?
                          LEXEME_CAPACITY : stt_pkg::LEX_BYTES;

  typedef logic [LEXEME_CAPACITY-1:0][7:0] lex_t;

  typedef enum logic [2:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_OP, M_C3_IDLE, M_C3_IDENT
  } mode_t;

  mode_t            mode, mode_next;
  logic [7:0]       held, held_next;
  stt_pkg::pos_t    cur_pos, cur_pos_next;
  stt_pkg::pos_t    start_pos, start_pos_next;
  logic [CNT_W-1:0] count, count_next;
  lex_t             lex, lex_next;

  function automatic stt_pkg::lexeme_t lex_view(lex_t l, logic [CNT_W-1:0] c);
    stt_pkg::lexeme_t v;
    v = '0;
    for (int k = 0; k < VIEW_N; k++) begin
      if (k < int'(c)) v[k] = l[k];
    end
    return v;
  endfunction

  function automatic stt_pkg::kind_t ident_kind(lex_t l, logic [CNT_W-1:0] c);
    stt_pkg::lexeme_t v;
    logic [4:0]       len;
    v   = lex_view(l, c);
    len = 5'(c);
    if (len == 5'd3 && v[2:0] == stt_pkg::KW_INT) return stt_pkg::KIND_INT;
    if (len == 5'd5 && v[4:0] == stt_pkg::KW_FLOAT) return stt_pkg::KIND_FLOAT;
    if (len == 5'd2 && v[1:0] == stt_pkg::KW_IF) return stt_pkg::KIND_IF;
    if (len == 5'd4 && v[3:0] == stt_pkg::KW_ELSE) return stt_pkg::KIND_ELSE;
    return stt_pkg::KIND_ID;
  endfunction

  function automatic stt_pkg::token_t make_tok(stt_pkg::kind_t kind, stt_pkg::pos_t p,
                                               logic [CNT_W-1:0] c, lex_t l);
    stt_pkg::token_t t;
    t.kind   = kind;
    t.line   = p.line;
    t.column = p.column;
    t.length = 5'(c);
    t.lexeme = lex_view(l, c);
    return t;
  endfunction

  always_comb begin
    mode_t            md;
    logic [7:0]       hb;
    stt_pkg::pos_t    cur;
    stt_pkg::pos_t    st;
    logic [CNT_W-1:0] cnt;
    lex_t             lx;
    logic [1:0]       n;
    stt_pkg::token_t [2:0] res;
    logic             do_idle;
    logic             do_lone;
    logic             chk;
    logic             chk_num;
    stt_pkg::kind_t   kind;

    md      = mode;
    hb      = held;
    cur     = cur_pos;
    st      = start_pos;
    cnt     = count;
    lx      = lex;
    n       = 2'd0;
    res     = '0;
    do_idle = 1'b0;
    do_lone = 1'b0;
    chk     = 1'b0;
    chk_num = 1'b0;
    kind    = stt_pkg::KIND_ERROR;

    if (restart) begin
      md  = M_IDLE;
      hb  = '0;
      cur = stt_pkg::POS_ONE;
      st  = stt_pkg::POS_ONE;
      cnt = '0;
    end

    // Phase 1: continue or close the token in progress
    case (md)
      M_IDENT: begin
        if (text_byte == stt_pkg::CH_C3) begin
          if (int'(cnt) < LEXEME_CAPACITY - 2) begin
            hb = text_byte;
            md = M_C3_IDENT;
          end else begin
            res[n]  = make_tok(ident_kind(lx, cnt), st, cnt, lx);
            n       = n + 2'd1;
            do_idle = 1'b1;
          end
        end else if (stt_pkg::is_alpha(text_byte) || stt_pkg::is_digit(text_byte) ||
                     stt_pkg::is_punct(text_byte)) begin
          lx[cnt] = text_byte;
          cnt     = CNT_W'(cnt + 1'b1);
          cur     = stt_pkg::consume(cur, text_byte);
          chk     = 1'b1;
        end else begin
          res[n]  = make_tok(ident_kind(lx, cnt), st, cnt, lx);
          n       = n + 2'd1;
          do_idle = 1'b1;
        end
      end
      M_NUMBER: begin
        if (stt_pkg::is_digit(text_byte)) begin
          lx[cnt] = text_byte;
          cnt     = CNT_W'(cnt + 1'b1);
          cur     = stt_pkg::consume(cur, text_byte);
          chk     = 1'b1;
          chk_num = 1'b1;
        end else begin
          res[n]  = make_tok(stt_pkg::KIND_NUMBER, st, cnt, lx);
          n       = n + 2'd1;
          do_idle = 1'b1;
        end
      end
      M_OP: begin
        if (text_byte == stt_pkg::CH_EQ) begin
          lx[cnt] = text_byte;
          cnt     = CNT_W'(cnt + 1'b1);
          cur     = stt_pkg::consume(cur, text_byte);
          if (hb == stt_pkg::CH_EQ) kind = stt_pkg::KIND_EQ;
          else if (hb == stt_pkg::CH_GT) kind = stt_pkg::KIND_GE;
          else kind = stt_pkg::KIND_LE;
          res[n]  = make_tok(kind, st, cnt, lx);
          n       = n + 2'd1;
          md      = M_IDLE;
        end else begin
          if (hb == stt_pkg::CH_EQ) kind = stt_pkg::KIND_ASSIGN;
          else if (hb == stt_pkg::CH_GT) kind = stt_pkg::KIND_GT;
          else kind = stt_pkg::KIND_LT;
          res[n]  = make_tok(kind, st, cnt, lx);
          n       = n + 2'd1;
          do_idle = 1'b1;
        end
      end
      M_C3_IDLE, M_C3_IDENT: begin
        if (stt_pkg::is_accent_tail(text_byte)) begin
          if (md == M_C3_IDLE) begin
            st  = cur;
            cnt = '0;
          end
          lx[cnt] = stt_pkg::CH_C3;
          cnt     = CNT_W'(cnt + 1'b1);
          cur     = stt_pkg::consume(cur, stt_pkg::CH_C3);
          lx[cnt] = text_byte;
          cnt     = CNT_W'(cnt + 1'b1);
          cur     = stt_pkg::consume(cur, text_byte);
          md      = M_IDENT;
          chk     = 1'b1;
        end else begin
          if (md == M_C3_IDENT) begin
            res[n] = make_tok(ident_kind(lx, cnt), st, cnt, lx);
            n      = n + 2'd1;
          end
          do_lone = 1'b1;
          do_idle = 1'b1;
        end
      end
      default: do_idle = 1'b1;
    endcase

    // Phase 2: a held 0xC3 with no valid tail becomes an error token
    if (do_lone) begin
      st     = cur;
      lx[0]  = stt_pkg::CH_C3;
      cnt    = CNT_W'(1);
      cur    = stt_pkg::consume(cur, stt_pkg::CH_C3);
      res[n] = make_tok(stt_pkg::KIND_ERROR, st, cnt, lx);
      n      = n + 2'd1;
    end

    // Phase 3: scan the byte from idle
    if (do_idle) begin
      md = M_IDLE;
      if (text_byte == stt_pkg::CH_NUL) begin
        st     = cur;
        cnt    = '0;
        res[n] = make_tok(stt_pkg::KIND_EOF, st, cnt, lx);
        n      = n + 2'd1;
      end else if (stt_pkg::is_space(text_byte)) begin
        cur = stt_pkg::consume(cur, text_byte);
      end else if (text_byte == stt_pkg::CH_C3) begin
        hb = text_byte;
        md = M_C3_IDLE;
      end else begin
        st     = cur;
        lx[0]  = text_byte;
        cnt    = CNT_W'(1);
        cur    = stt_pkg::consume(cur, text_byte);
        if (stt_pkg::is_alpha(text_byte) || stt_pkg::is_punct(text_byte)) begin
          md  = M_IDENT;
          chk = 1'b1;
        end else if (stt_pkg::is_digit(text_byte)) begin
          md      = M_NUMBER;
          chk     = 1'b1;
          chk_num = 1'b1;
        end else if (text_byte == stt_pkg::CH_EQ || text_byte == stt_pkg::CH_GT ||
                     text_byte == stt_pkg::CH_LT) begin
          hb = text_byte;
          md = M_OP;
        end else begin
          case (text_byte)
            stt_pkg::CH_PLUS:   kind = stt_pkg::KIND_PLUS;
            stt_pkg::CH_MINUS:  kind = stt_pkg::KIND_MINUS;
            stt_pkg::CH_SEMI:   kind = stt_pkg::KIND_SEMI;
            stt_pkg::CH_LPAREN: kind = stt_pkg::KIND_LPAREN;
            stt_pkg::CH_RPAREN: kind = stt_pkg::KIND_RPAREN;
            stt_pkg::CH_LBRACE: kind = stt_pkg::KIND_LBRACE;
            stt_pkg::CH_RBRACE: kind = stt_pkg::KIND_RBRACE;
            default:            kind = stt_pkg::KIND_ERROR;
          endcase
          res[n] = make_tok(kind, st, cnt, lx);
          n      = n + 2'd1;
        end
      end
    end

    // Length cut: a full identifier or number goes out now
    if (chk && int'(cnt) >= LEXEME_CAPACITY - 1) begin
      res[n] = make_tok(chk_num ? stt_pkg::KIND_NUMBER : ident_kind(lx, cnt), st, cnt, lx);
      n      = n + 2'd1;
      md     = M_IDLE;
    end

    mode_next      = md;
    held_next      = hb;
    cur_pos_next   = cur;
    start_pos_next = st;
    count_next     = cnt;
    lex_next       = lx;
    result.count   = n;
    result.tok     = res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      held      <= '0;
      cur_pos   <= stt_pkg::POS_ONE;
      start_pos <= stt_pkg::POS_ONE;
      count     <= '0;
    end else if (step) begin
      mode      <= mode_next;
      held      <= held_next;
      cur_pos   <= cur_pos_next;
      start_pos <= start_pos_next;
      count     <= count_next;
    end
    if (step) lex <= lex_next;
  end

endmodule

// File: rtl/source_text_tokenizer_top.sv
// Top level of the source text tokenizer: stream ports, result queue and
// checks. Depends on stt_pkg and stt_scan.
//
// Usage:
//  - Slave stream takes one source byte per transaction: tdata holds the byte,
//    tuser is the restart flag (drop any pending token, line/column back to 1).
//    Byte zero ends the text and yields an eof token; scanning then goes on.
//  - Master stream gives tokens: tuser is the token kind, tdata holds start
//    line, start column, lexeme length and the four lexeme words; tlast marks
//    the final token caused by one source byte.
//  - Latency: tokens of a byte appear on the master side the cycle after the
//    byte is taken.
//  - Throughput: one byte per cycle while each byte gives at most one token and
//    tready stays high. A byte giving k tokens (k up to 3) holds the queue until
//    all k have left, the master side draining one token per cycle with tready
//    high; the queue refills in the same cycle its last entry leaves.
//  - Stall: while the receiver holds tready low the queue holds its tokens and
//    s_axis_tready stays low; no byte or token is dropped.
//  - Reset: synchronous; clears scan state, position to line 1 column 1, and
//    empties the queue. The lexeme store is not cleared.
module source_text_tokenizer_top #(
  parameter int LEXEME_CAPACITY = 32
) (
  input  logic         clk,
  input  logic         rst,
  // byte stream in
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] text_byte
  input  logic         s_axis_tuser,   // [0] restart
  // token stream out
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [295:0] m_axis_tdata,   // [15:0] token_line, [31:16] token_column,
                                       // [36:32] lexeme_length, [100:37] lexeme_word0,
                                       // [164:101] lexeme_word1, [228:165] lexeme_word2,
                                       // [292:229] lexeme_word3, [295:293] zero
  output logic [4:0]   m_axis_tuser,   // [4:0] token_kind
  output logic         m_axis_tlast    // last_of_run
);

  stt_pkg::step_out_t    scan_out;
  stt_pkg::token_t [2:0] q;         // q[0] is on the master side
  logic [2:0]            q_last;
  logic [1:0]            q_cnt;
  logic                  in_take;
  logic                  out_take;

  // Take a byte when the queue is empty or its last token leaves now
  assign s_axis_tready = (q_cnt == 2'd0) || (q_cnt == 2'd1 && m_axis_tready);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign out_take      = m_axis_tvalid && m_axis_tready;

  stt_scan #(
    .LEXEME_CAPACITY(LEXEME_CAPACITY)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .step     (in_take),
    .text_byte(s_axis_tdata),
    .restart  (s_axis_tuser),
    .result   (scan_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= 2'd0;
    end else if (in_take) begin
      q_cnt <= scan_out.count;
    end else if (out_take) begin
      q_cnt <= q_cnt - 2'd1;
    end
    if (in_take) begin
      q <= scan_out.tok;
      for (int i = 0; i < 3; i++) begin
        q_last[i] <= (2'(i + 1) == scan_out.count);
      end
    end else if (out_take) begin
      q[0]      <= q[1];
      q[1]      <= q[2];
      q_last[0] <= q_last[1];
      q_last[1] <= q_last[2];
    end
  end

  assign m_axis_tvalid = (q_cnt != 2'd0);
  assign m_axis_tuser  = q[0].kind;
  assign m_axis_tlast  = q_last[0];
  assign m_axis_tdata  = {3'b000,
                          8'h00, q[0].lexeme[30:24],
                          q[0].lexeme[23:16],
                          q[0].lexeme[15:8],
                          q[0].lexeme[7:0],
                          q[0].length,
                          q[0].column,
                          q[0].line};

  // Only the final queued token of a byte carries tlast
  a_last_at_tail: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (q_cnt == 2'd1)))
    else $error("tlast does not match the queue tail");

  // A taken byte shows its first token in the next cycle, if it has any
  a_tokens_follow: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (m_axis_tvalid == ($past(scan_out.count) != 2'd0)))
    else $error("token output does not follow the taken byte");

  // Positions start at one and saturate, never wrap to zero
  a_pos_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (q[0].line != 16'd0 && q[0].column != 16'd0))
    else $error("token position is zero");

  // No new byte while more than one token still waits
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (q_cnt > 2'd1) |-> !s_axis_tready)
    else $error("byte taken with tokens still queued");

endmodule
